// ===== rtl/selective_repeat_rx_window_core_macros.svh =====
// assertion helpers for the receive window core
`ifndef SELECTIVE_REPEAT_RX_WINDOW_CORE_MACROS_SVH
`define SELECTIVE_REPEAT_RX_WINDOW_CORE_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define SRW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// property that must hold in the cycle after its trigger
`define SRW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/srw_pkg.sv =====
package srw_pkg;

   // default number of tracked sequence numbers
   localparam int WINDOW_DEFAULT = 64;

   // operation codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // state of a sequence number as reported in a response
   typedef enum logic [1:0] {
      SEQ_UNSEEN   = 2'd0,
      SEQ_MISSING  = 2'd1,
      SEQ_RECEIVED = 2'd2
   } seq_state_type;

   // status handed from the lookup logic to the top level
   typedef struct packed {
      seq_state_type seq_state;
      logic          overflow;
   } srw_status_type;

endpackage

// ===== rtl/srw_lookup.sv =====
module srw_lookup #(
   parameter int WINDOW = srw_pkg::WINDOW_DEFAULT
) (
   input  logic                         operation,
   input  logic [31:0]                  seq,
   input  logic [31:0]                  base_seq,
   input  logic [$clog2(WINDOW+1)-1:0]  window_fill,
   input  logic [WINDOW-1:0]            received_map,
   output logic [WINDOW-1:0]            marked_map,
   output logic [$clog2(WINDOW+1)-1:0]  marked_fill,
   output srw_pkg::srw_status_type      status
);
   import srw_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);

   logic [31:0]       next_seq;
   logic [31:0]       offset;
   logic [31:0]       gap;
   logic [FILL_W:0]   need;
   logic              gap_fits;
   logic              too_big;
   seq_state_type     state;

   assign next_seq = base_seq + 32'(window_fill);
   assign offset   = seq - base_seq;
   assign gap      = seq - next_seq;

   // classify the number against the current window
   always_comb begin
      if (seq >= next_seq) begin
         state = SEQ_UNSEEN;
      end else if (seq < base_seq) begin
         state = SEQ_RECEIVED;
      end else if (offset >= 32'(window_fill)) begin
         state = SEQ_RECEIVED;
      end else if (received_map[offset[IDX_W-1:0]]) begin
         state = SEQ_RECEIVED;
      end else begin
         state = SEQ_MISSING;
      end
   end

   // size of the window if the gap were opened
   assign gap_fits = gap < 32'(WINDOW);
   assign need     = (FILL_W+1)'(window_fill) + (FILL_W+1)'(gap[IDX_W-1:0]) + 1'b1;
   assign too_big  = !gap_fits || (need > (FILL_W+1)'(WINDOW));

   // mark the received number and grow the window
   always_comb begin
      marked_map       = received_map;
      marked_fill      = window_fill;
      status.seq_state = state;
      status.overflow  = 1'b0;
      if (operation == OP_RECORD) begin
         unique case (state)
            SEQ_UNSEEN: begin
               if (too_big) begin
                  status.overflow = 1'b1;
               end else begin
                  marked_map[IDX_W'(need - 1'b1)] = 1'b1;
                  marked_fill                     = FILL_W'(need);
               end
            end
            SEQ_MISSING: begin
               marked_map[offset[IDX_W-1:0]] = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/srw_slide.sv =====
module srw_slide #(
   parameter int WINDOW = srw_pkg::WINDOW_DEFAULT
) (
   input  logic [WINDOW-1:0]            marked_map,
   input  logic [$clog2(WINDOW+1)-1:0]  marked_fill,
   input  logic [31:0]                  base_seq,
   output logic [WINDOW-1:0]            slid_map,
   output logic [$clog2(WINDOW+1)-1:0]  slid_fill,
   output logic [31:0]                  slid_base
);
   import srw_pkg::*;

   localparam int FILL_W = $clog2(WINDOW + 1);

   logic [FILL_W-1:0] lead_count;

   // first missing mark gives the number of leading received marks
   always_comb begin
      lead_count = FILL_W'(WINDOW);
      for (int i = WINDOW - 1; i >= 0; i--) begin
         if (!marked_map[i]) begin
            lead_count = FILL_W'(i);
         end
      end
   end

   // drop them and advance the base
   assign slid_map  = marked_map >> lead_count;
   assign slid_fill = marked_fill - lead_count;
   assign slid_base = base_seq + 32'(lead_count);

endmodule

// ===== rtl/selective_repeat_rx_window_core.sv =====
// Selective-repeat receive window. Each request either records a received sequence
// number (operation 0) or queries one (operation 1); every request yields exactly one
// response with the number's state before the request, the window base and next
// expected number after it, and an overflow flag when a record is dropped because the
// window would need more than WINDOW marks. Numbers compare as plain unsigned 32-bit
// values. One request is accepted per cycle when req_stall is low; the input register
// takes it and its response is loaded into the result register when that register is
// empty or its response is not stalled. The mark update, the leading-ones count and
// the barrel shift of the WINDOW-bit received map lie combinationally between the two
// registers and set the clock rate.
module selective_repeat_rx_window_core #(
   parameter int WINDOW = srw_pkg::WINDOW_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [31:0] req_seq,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_seq_state,
   output logic [31:0] rsp_window_base,
   output logic [31:0] rsp_next_expected,
   output logic        rsp_overflow
);
   import srw_pkg::*;

   localparam int FILL_W = $clog2(WINDOW + 1);

   logic              in_valid_ff;
   logic              in_operation_ff;
   logic [31:0]       in_seq_ff;
   logic              out_valid_ff;
   logic [1:0]        out_state_ff;
   logic [31:0]       out_base_ff;
   logic [31:0]       out_next_ff;
   logic              out_overflow_ff;
   logic [31:0]       base_ff;
   logic [31:0]       base_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [WINDOW-1:0] map_ff;
   logic [WINDOW-1:0] map_in;

   logic [WINDOW-1:0] marked_map;
   logic [FILL_W-1:0] marked_fill;
   logic [WINDOW-1:0] slid_map;
   logic [FILL_W-1:0] slid_fill;
   logic [31:0]       slid_base;
   srw_status_type    status;
   logic              advance;
   logic              take_req;
   logic              update;

   // handshake
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;
   assign update    = advance && (in_operation_ff == OP_RECORD);

   srw_lookup #(.WINDOW(WINDOW)) u_lookup (
      .operation    (in_operation_ff),
      .seq          (in_seq_ff),
      .base_seq     (base_ff),
      .window_fill  (fill_ff),
      .received_map (map_ff),
      .marked_map   (marked_map),
      .marked_fill  (marked_fill),
      .status       (status)
   );

   srw_slide #(.WINDOW(WINDOW)) u_slide (
      .marked_map  (marked_map),
      .marked_fill (marked_fill),
      .base_seq    (base_ff),
      .slid_map    (slid_map),
      .slid_fill   (slid_fill),
      .slid_base   (slid_base)
   );

   // window state after this request
   assign base_in = update ? slid_base : base_ff;
   assign fill_in = update ? slid_fill : fill_ff;
   assign map_in  = update ? slid_map  : map_ff;

   // window state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         fill_ff <= '0;
         map_ff  <= '0;
      end else begin
         base_ff <= base_in;
         fill_ff <= fill_in;
         map_ff  <= map_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_operation_ff <= req_operation;
         in_seq_ff       <= req_seq;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_state_ff    <= 2'(status.seq_state);
         out_base_ff     <= base_in;
         out_next_ff     <= base_in + 32'(fill_in);
         out_overflow_ff <= status.overflow;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_seq_state     = out_state_ff;
   assign rsp_window_base   = out_base_ff;
   assign rsp_next_expected = out_next_ff;
   assign rsp_overflow      = out_overflow_ff;

endmodule

// ===== rtl/srw_checker.sv =====
`include "selective_repeat_rx_window_core_macros.svh"

module srw_checker #(
   parameter int WINDOW = srw_pkg::WINDOW_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_operation,
   input logic [31:0] req_seq,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_seq_state,
   input logic [31:0] rsp_window_base,
   input logic [31:0] rsp_next_expected,
   input logic        rsp_overflow
);
   import srw_pkg::*;

   logic [31:0] span;
   assign span = rsp_next_expected - rsp_window_base;

   // a stalled response holds
   `SRW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_seq_state) && $stable(rsp_window_base) &&
      $stable(rsp_next_expected) && $stable(rsp_overflow), "stalled response changed")

   // only defined state codes leave the block
   `SRW_ASSERT_NOW(a_state_code, rsp_valid,
      rsp_seq_state == 2'(SEQ_UNSEEN) || rsp_seq_state == 2'(SEQ_MISSING) ||
      rsp_seq_state == 2'(SEQ_RECEIVED), "undefined sequence state")

   // the window never spans more than its size
   `SRW_ASSERT_NOW(a_window_span, rsp_valid, span <= 32'(WINDOW), "window wider than its size")

   // a dropped record was always for an unseen number
   `SRW_ASSERT_NOW(a_overflow_unseen, rsp_valid && rsp_overflow,
      rsp_seq_state == 2'(SEQ_UNSEEN), "overflow on a number inside the window")

   // a stalled request holds
   `SRW_ASSERT_NEXT(a_req_hold, req_valid && req_stall,
      req_valid && $stable(req_operation) && $stable(req_seq), "stalled request changed")

endmodule

bind selective_repeat_rx_window_core srw_checker #(.WINDOW(WINDOW)) u_srw_checker (.*);
